// ===== rtl/core/sprite_motion_bounce_animate_macros.svh =====
// Assertion macros shared by the sprite motion RTL.
// No dependencies; included by modules that carry assertions.
`ifndef SPRITE_MOTION_BOUNCE_ANIMATE_MACROS_SVH
`define SPRITE_MOTION_BOUNCE_ANIMATE_MACROS_SVH

// same-cycle implication
`define SMBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smba_pkg.sv =====
// Types and constants for the sprite motion / bounce / animation block.
// No dependencies; used by sprite_motion_bounce_animate.
package smba_pkg;

   localparam int POS_W       = 24;
   localparam int MS_W        = 10;
   localparam int EDGE_W      = 16;
   localparam int ACC_W       = 17;
   localparam int FRAME_W     = 4;
   localparam int FCOUNT_W    = 5;
   localparam int INTERVAL_W  = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_FRAMES  = 16;

   // shared multiplier: |v|*ms, then ((p + 500) >> 3) * ceil(2^38 / 125)
   localparam int MUL_A_W     = 31;
   localparam int MUL_B_W     = 32;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int RAW_W       = 34;
   localparam int RECIP_SHIFT = 38;
   localparam logic [MUL_B_W-1:0] RECIP_125  = 32'd2199023256;
   localparam logic [RAW_W:0]     ROUND_BIAS = 35'd500;

   localparam logic [ACC_W-1:0]      ACC_MAX             = 17'h1FFFF;
   localparam logic [INTERVAL_W-1:0] FRAME_INTERVAL_RST  = 16'd100;
   localparam logic [FCOUNT_W-1:0]   FRAME_COUNT_RST     = 5'd1;
   localparam logic [EDGE_W-1:0]     MAX_X_EDGE_RST      = 16'd639;
   localparam logic [EDGE_W-1:0]     MAX_Y_EDGE_RST      = 16'd479;

   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_POS_Y,
      ST_BOUNCE,
      ST_DONE
   } smba_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_INTERVAL = 3'd0,
      CSR_FRAME_COUNT    = 3'd1,
      CSR_TWO_WAY_MODE   = 3'd2,
      CSR_MIN_X_EDGE     = 3'd3,
      CSR_MIN_Y_EDGE     = 3'd4,
      CSR_MAX_X_EDGE     = 3'd5,
      CSR_MAX_Y_EDGE     = 3'd6
   } smba_csr_type;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_LOAD    = 1'b1
   } smba_op_type;

endpackage

// ===== rtl/core/sprite_motion_bounce_animate.sv =====
// Sprite motion, edge bounce and frame animation, one item at a time.
// Depends on smba_pkg and sprite_motion_bounce_animate_macros.svh.
//
// Usage:
//   req_* carries one item: an advance (elapsed_ms) or a load of position
//   and velocity. An item is taken when req_valid is high and req_stall low.
//   rsp_* returns one item per request: position, velocity and frame after
//   the step. csr_* writes the seven setup registers (index, data); csr_ready
//   is always high; writes are to be made only while the block is idle
//   by the user; the block does not enforce it. An advance item runs
//   through MUL_X, DIV_X, MUL_Y, DIV_Y, POS_Y, BOUNCE and DONE and shows on
//   rsp_valid when it leaves DONE. The one 31x32 multiplier runs four times
//   in turn (|vx|*ms, divide by 1000 through a reciprocal, then the same for
//   y); the frame modulo runs beside it as a five-step compare and subtract.
//   A load item goes straight to DONE. req_stall is high while an item is
//   in work.
// Reset: synchronous, active high; state clears to zero and the setup
//   registers take their default values. No clearing pass.
// Stall: rsp_* sits in an output register; a new item may be taken while a
//   result waits, and that item holds in its last state until rsp is free.
module sprite_motion_bounce_animate #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [smba_pkg::MS_W-1:0]            req_elapsed_ms,
   input  logic signed [smba_pkg::POS_W-1:0]    req_load_pos_x,
   input  logic signed [smba_pkg::POS_W-1:0]    req_load_pos_y,
   input  logic signed [smba_pkg::POS_W-1:0]    req_load_vel_x,
   input  logic signed [smba_pkg::POS_W-1:0]    req_load_vel_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [smba_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [smba_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [smba_pkg::POS_W-1:0]    rsp_vel_x,
   output logic signed [smba_pkg::POS_W-1:0]    rsp_vel_y,
   output logic [smba_pkg::FRAME_W-1:0]         rsp_frame_index,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [smba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smba_pkg::CSR_DATA_W-1:0]      csr_data
);

`include "sprite_motion_bounce_animate_macros.svh"

   localparam int POS_W  = smba_pkg::POS_W;
   localparam int FX_W   = smba_pkg::EDGE_W + FRAC_BITS;
   localparam int CMP_W  = (FX_W > POS_W) ? FX_W : POS_W;
   localparam int SUM_W  = POS_W + 2;
   localparam int DS_W   = smba_pkg::FCOUNT_W + 4;

   // setup registers
   logic [smba_pkg::INTERVAL_W-1:0]    interval_ff, interval_in;
   logic [smba_pkg::FCOUNT_W-1:0]      fcount_ff, fcount_in;
   logic                               two_way_ff, two_way_in;
   logic signed [smba_pkg::EDGE_W-1:0] min_x_ff, min_x_in;
   logic signed [smba_pkg::EDGE_W-1:0] min_y_ff, min_y_in;
   logic signed [smba_pkg::EDGE_W-1:0] max_x_ff, max_x_in;
   logic signed [smba_pkg::EDGE_W-1:0] max_y_ff, max_y_in;

   // sprite state
   logic signed [POS_W-1:0]            pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]            pos_y_ff, pos_y_in;
   logic signed [POS_W-1:0]            vel_x_ff, vel_x_in;
   logic signed [POS_W-1:0]            vel_y_ff, vel_y_in;
   logic [smba_pkg::FRAME_W-1:0]       frame_ff, frame_in;
   logic [smba_pkg::ACC_W-1:0]         acc_ff, acc_in;

   // sequencer and work registers
   smba_pkg::smba_state_type           state_ff, state_in;
   logic [smba_pkg::MS_W-1:0]          ms_ff, ms_in;
   logic [smba_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                               adv_ff, adv_in;
   logic                               div_zero_ff, div_zero_in;
   logic                               upper_ff, upper_in;
   logic [smba_pkg::FCOUNT_W-1:0]      div_ff, div_in;
   logic [smba_pkg::FCOUNT_W-1:0]      rem_ff, rem_in;
   logic [DS_W-1:0]                    ds_ff, ds_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]            rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [POS_W-1:0]            rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [POS_W-1:0]            rsp_vel_x_ff, rsp_vel_x_in;
   logic signed [POS_W-1:0]            rsp_vel_y_ff, rsp_vel_y_in;
   logic [smba_pkg::FRAME_W-1:0]       rsp_frame_ff, rsp_frame_in;

   // datapath nets
   logic [smba_pkg::MUL_A_W-1:0]       mul_a;
   logic [smba_pkg::MUL_B_W-1:0]       mul_b;
   logic [smba_pkg::PROD_W-1:0]        mul_p;
   logic signed [POS_W-1:0]            mag_src;
   logic [POS_W-1:0]                   mag;
   logic [smba_pkg::RAW_W:0]           rnd;
   logic [smba_pkg::MUL_A_W-1:0]       quo_in;
   logic [POS_W-1:0]                   quo;
   logic signed [POS_W-1:0]            upd_vel;
   logic signed [POS_W-1:0]            upd_pos;
   logic signed [SUM_W-1:0]            disp;
   logic signed [SUM_W-1:0]            pos_sum;
   logic signed [POS_W-1:0]            pos_sat;
   logic                               rem_ge;
   logic [smba_pkg::FCOUNT_W-1:0]      rem_step;
   logic [smba_pkg::ACC_W:0]           acc_sum;
   logic [smba_pkg::ACC_W-1:0]         acc_sat;
   logic [smba_pkg::FCOUNT_W-1:0]      n_eff;
   logic [smba_pkg::FCOUNT_W-1:0]      div_init;
   logic [smba_pkg::FCOUNT_W-1:0]      frame_sum;
   logic signed [CMP_W-1:0]            min_x_fx, min_y_fx, max_x_fx, max_y_fx;
   logic                               rsp_free;

   function automatic logic signed [POS_W-1:0] abs_sat(input logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v == smba_pkg::POS_MIN) begin
         r = smba_pkg::POS_MAX;
      end else if (v < 0) begin
         r = -v;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] bounce_vel(
      input logic signed [POS_W-1:0] pos,
      input logic signed [CMP_W-1:0] lo,
      input logic signed [CMP_W-1:0] hi,
      input logic signed [POS_W-1:0] v
   );
      logic signed [CMP_W-1:0] p;
      logic signed [POS_W-1:0] r;
      p = CMP_W'(pos);
      r = v;
      if (p < lo) begin
         r = abs_sat(v);
      end
      if (p > hi) begin
         r = -abs_sat(v);
      end
      return r;
   endfunction

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != smba_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_vel_x       = rsp_vel_x_ff;
   assign rsp_vel_y       = rsp_vel_y_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_free        = !rsp_valid_ff || !rsp_stall;

   assign min_x_fx = CMP_W'(min_x_ff) <<< FRAC_BITS;
   assign min_y_fx = CMP_W'(min_y_ff) <<< FRAC_BITS;
   assign max_x_fx = CMP_W'(max_x_ff) <<< FRAC_BITS;
   assign max_y_fx = CMP_W'(max_y_ff) <<< FRAC_BITS;

   // shared multiplier
   assign mag_src = (state_ff == smba_pkg::ST_MUL_Y) ? vel_y_ff : vel_x_ff;
   assign mag     = mag_src[POS_W-1] ? POS_W'(-mag_src) : POS_W'(mag_src);
   assign rnd     = {1'b0, prod_ff[smba_pkg::RAW_W-1:0]} + smba_pkg::ROUND_BIAS;
   assign quo_in  = rnd[smba_pkg::RAW_W-1:3];
   assign mul_p   = smba_pkg::PROD_W'(mul_a) * smba_pkg::PROD_W'(mul_b);

   always_comb begin
      mul_a = smba_pkg::MUL_A_W'(mag);
      mul_b = smba_pkg::MUL_B_W'(ms_ff);
      if (state_ff == smba_pkg::ST_DIV_X || state_ff == smba_pkg::ST_DIV_Y) begin
         mul_a = quo_in;
         mul_b = smba_pkg::RECIP_125;
      end
   end

   // rounded quotient, signed displacement and saturated position
   assign quo     = prod_ff[smba_pkg::RECIP_SHIFT +: POS_W];
   assign upd_vel = (state_ff == smba_pkg::ST_POS_Y) ? vel_y_ff : vel_x_ff;
   assign upd_pos = (state_ff == smba_pkg::ST_POS_Y) ? pos_y_ff : pos_x_ff;
   assign disp    = upd_vel[POS_W-1] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
   assign pos_sum = SUM_W'(upd_pos) + disp;
   assign pos_sat = (pos_sum > SUM_W'(smba_pkg::POS_MAX)) ? smba_pkg::POS_MAX :
                    (pos_sum < SUM_W'(smba_pkg::POS_MIN)) ? smba_pkg::POS_MIN :
                    pos_sum[POS_W-1:0];

   // frame modulo: one compare/subtract per cycle
   assign rem_ge   = {4'b0, rem_ff} >= ds_ff;
   assign rem_step = rem_ge ? smba_pkg::FCOUNT_W'({4'b0, rem_ff} - ds_ff) : rem_ff;

   assign acc_sum  = {1'b0, acc_ff} + (smba_pkg::ACC_W + 1)'(req_elapsed_ms);
   assign acc_sat  = (acc_sum > {1'b0, smba_pkg::ACC_MAX}) ? smba_pkg::ACC_MAX :
                     acc_sum[smba_pkg::ACC_W-1:0];
   assign n_eff    = (32'(fcount_ff) > 32'(smba_pkg::MAX_FRAMES)) ?
                     smba_pkg::FCOUNT_W'(smba_pkg::MAX_FRAMES) : fcount_ff;
   assign div_init = two_way_ff ? (n_eff >> 1) : n_eff;
   assign frame_sum = upper_ff ? (div_ff + rem_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= smba_pkg::FRAME_INTERVAL_RST;
         fcount_ff    <= smba_pkg::FRAME_COUNT_RST;
         two_way_ff   <= 1'b0;
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         max_x_ff     <= smba_pkg::MAX_X_EDGE_RST;
         max_y_ff     <= smba_pkg::MAX_Y_EDGE_RST;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         frame_ff     <= '0;
         acc_ff       <= '0;
         adv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
         fcount_ff    <= fcount_in;
         two_way_ff   <= two_way_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         frame_ff     <= frame_in;
         acc_ff       <= acc_in;
         adv_ff       <= adv_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_ff        <= ms_in;
      prod_ff      <= prod_in;
      div_zero_ff  <= div_zero_in;
      upper_ff     <= upper_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      ds_ff        <= ds_in;
      rsp_pos_x_ff <= rsp_pos_x_in;
      rsp_pos_y_ff <= rsp_pos_y_in;
      rsp_vel_x_ff <= rsp_vel_x_in;
      rsp_vel_y_ff <= rsp_vel_y_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      fcount_in    = fcount_ff;
      two_way_in   = two_way_ff;
      min_x_in     = min_x_ff;
      min_y_in     = min_y_ff;
      max_x_in     = max_x_ff;
      max_y_in     = max_y_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      frame_in     = frame_ff;
      acc_in       = acc_ff;
      ms_in        = ms_ff;
      prod_in      = prod_ff;
      adv_in       = adv_ff;
      div_zero_in  = div_zero_ff;
      upper_in     = upper_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      ds_in        = ds_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_x_in = rsp_pos_x_ff;
      rsp_pos_y_in = rsp_pos_y_ff;
      rsp_vel_x_in = rsp_vel_x_ff;
      rsp_vel_y_in = rsp_vel_y_ff;
      rsp_frame_in = rsp_frame_ff;

      if (csr_valid) begin
         case (csr_index)
            smba_pkg::CSR_FRAME_INTERVAL: interval_in = csr_data;
            smba_pkg::CSR_FRAME_COUNT:    fcount_in   = csr_data[smba_pkg::FCOUNT_W-1:0];
            smba_pkg::CSR_TWO_WAY_MODE:   two_way_in  = csr_data[0];
            smba_pkg::CSR_MIN_X_EDGE:     min_x_in    = csr_data;
            smba_pkg::CSR_MIN_Y_EDGE:     min_y_in    = csr_data;
            smba_pkg::CSR_MAX_X_EDGE:     max_x_in    = csr_data;
            smba_pkg::CSR_MAX_Y_EDGE:     max_y_in    = csr_data;
            default: ;
         endcase
      end

      if (state_ff == smba_pkg::ST_MUL_X || state_ff == smba_pkg::ST_DIV_X ||
          state_ff == smba_pkg::ST_MUL_Y || state_ff == smba_pkg::ST_DIV_Y ||
          state_ff == smba_pkg::ST_POS_Y) begin
         rem_in = rem_step;
         ds_in  = ds_ff >> 1;
      end

      case (state_ff)
         smba_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == smba_pkg::OP_LOAD) begin
                  pos_x_in = req_load_pos_x;
                  pos_y_in = req_load_pos_y;
                  vel_x_in = req_load_vel_x;
                  vel_y_in = req_load_vel_y;
                  adv_in   = 1'b0;
                  state_in = smba_pkg::ST_DONE;
               end else begin
                  ms_in       = req_elapsed_ms;
                  adv_in      = acc_sat > smba_pkg::ACC_W'(interval_ff);
                  acc_in      = adv_in ? '0 : acc_sat;
                  div_in      = div_init;
                  div_zero_in = (div_init == '0);
                  upper_in    = two_way_ff && vel_x_ff[POS_W-1];
                  rem_in      = smba_pkg::FCOUNT_W'(frame_ff) + 1'b1;
                  ds_in       = {div_init, 4'b0};
                  state_in    = smba_pkg::ST_MUL_X;
               end
            end
         end
         smba_pkg::ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = smba_pkg::ST_DIV_X;
         end
         smba_pkg::ST_DIV_X: begin
            prod_in  = mul_p;
            state_in = smba_pkg::ST_MUL_Y;
         end
         smba_pkg::ST_MUL_Y: begin
            pos_x_in = pos_sat;
            prod_in  = mul_p;
            state_in = smba_pkg::ST_DIV_Y;
         end
         smba_pkg::ST_DIV_Y: begin
            prod_in  = mul_p;
            state_in = smba_pkg::ST_POS_Y;
         end
         smba_pkg::ST_POS_Y: begin
            pos_y_in = pos_sat;
            state_in = smba_pkg::ST_BOUNCE;
         end
         smba_pkg::ST_BOUNCE: begin
            vel_y_in = bounce_vel(pos_y_ff, min_y_fx, max_y_fx, vel_y_ff);
            vel_x_in = bounce_vel(pos_x_ff, min_x_fx, max_x_fx, vel_x_ff);
            if (adv_ff) begin
               frame_in = div_zero_ff ? '0 : frame_sum[smba_pkg::FRAME_W-1:0];
            end
            state_in = smba_pkg::ST_DONE;
         end
         smba_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_x_in = pos_x_ff;
               rsp_pos_y_in = pos_y_ff;
               rsp_vel_x_in = vel_x_ff;
               rsp_vel_y_in = vel_y_ff;
               rsp_frame_in = frame_ff;
               state_in     = smba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smba_pkg::ST_IDLE;
         end
      endcase
   end

   `SMBA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall,
      state_ff != smba_pkg::ST_IDLE, "item accepted but sequencer stayed idle")
   `SMBA_ASSERT_NOW(a_mod_done, clock, reset,
      state_ff == smba_pkg::ST_BOUNCE && adv_ff && !div_zero_ff,
      rem_ff < div_ff, "frame remainder not below divisor")
   `SMBA_ASSERT_NOW(a_acc_bound, clock, reset, state_ff == smba_pkg::ST_BOUNCE,
      acc_ff <= smba_pkg::ACC_W'(interval_ff), "accumulator above frame interval")
   `SMBA_ASSERT_NEXT(a_done_hold, clock, reset,
      state_ff == smba_pkg::ST_DONE && rsp_valid_ff && rsp_stall,
      state_ff == smba_pkg::ST_DONE, "result overwrote a stalled item")

endmodule
